// ----- src/ble_pkg.sv -----
// Shared types and constants for the size-budgeted LRU eviction block.
// No dependencies.
package ble_pkg;
  localparam int unsigned EntriesDefault = 16;
  localparam int unsigned SizeW = 40;
  localparam int unsigned StampW = 32;
  localparam int unsigned TotalW = 46;
  localparam int unsigned IdxW = 6;
  localparam int unsigned BudgetW = 10;
  localparam int unsigned GibShift = 30;
  localparam logic [BudgetW-1:0] BudgetReset = 10'd10;

  typedef enum logic [2:0] {
    OP_RECORD = 3'd0,
    OP_TOUCH = 3'd1,
    OP_SET_ACTIVE = 3'd2,
    OP_CLR_ACTIVE = 3'd3,
    OP_SET_PINNED = 3'd4,
    OP_REMOVE = 3'd5,
    OP_ENFORCE = 3'd6,
    OP_QUERY = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_OVER = 2'd2;
endpackage

// ----- src/budget_lru_evictor.sv -----
// Top level of the size-budgeted LRU eviction table: control sequencer,
// mark flip-flops, running total and output register. Depends on ble_pkg and ble_store.
//
//  channel | direction | signals
//  in      | input     | in_valid, in_stall, operation, entry_index, flag_value, entry_size
//  out     | output    | out_valid, out_stall, result_index ... status
//  cfg     | input     | cfg_we, cfg_data (budget_gb)
//
// A table operation reads the entry's size from memory at the accepting edge; S_APPLY
// then writes the result, the marks, the running total and the stamp. Enforce evicts
// the least recently used valid, unpinned, inactive entry while the budget is exceeded,
// and stops when it holds or a scan finds no candidate. Reset is synchronous; the size
// and stamp memories need no clearing. The input stall is high whenever the sequencer is
// busy, and a result waiting in the output register holds the sequencer.
module budget_lru_evictor #(
  parameter int unsigned ENTRIES = ble_pkg::EntriesDefault,
  localparam int unsigned AW = $clog2(ENTRIES),
  localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ble_pkg::BudgetW-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] operation,
  input  logic [ble_pkg::IdxW-1:0] entry_index,
  input  logic flag_value,
  input  logic [ble_pkg::SizeW-1:0] entry_size,
  output logic out_valid,
  input  logic out_stall,
  output logic [ble_pkg::IdxW-1:0] result_index,
  output logic evicted,
  output logic last_result,
  output logic entry_pinned,
  output logic entry_active,
  output logic [ble_pkg::TotalW-1:0] ephemeral_total,
  output logic [1:0] status
);
  typedef enum logic [2:0] {
    S_IDLE, S_APPLY, S_CHECK, S_SCAN, S_EREAD, S_EAPPLY, S_FINISH
  } state_t;

  state_t state;
  logic [ble_pkg::BudgetW-1:0] budget_gb;
  logic [ENTRIES-1:0] valid_marks, pinned_marks, active_marks;
  logic [ble_pkg::StampW-1:0] use_counter;
  ble_pkg::op_t op;
  logic [ble_pkg::IdxW-1:0] idx;
  logic flag;
  logic [ble_pkg::SizeW-1:0] size_in;
  logic [ble_pkg::TotalW-1:0] eph_total;
  logic [CW-1:0] scan_cnt;
  logic scan_pend;
  logic found;
  logic [AW-1:0] best;
  logic [ble_pkg::StampW-1:0] best_stamp;
  logic held;
  logic [AW-1:0] held_idx;
  logic [ble_pkg::SizeW-1:0] rsize;
  logic [ble_pkg::StampW-1:0] rstamp;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] eidx;
  logic in_range;
  logic [ble_pkg::TotalW-1:0] budget_bytes;
  logic over;
  logic out_free;
  logic emit;
  logic scan_last;
  logic elig;
  logic take;
  logic cur_v, cur_p, cur_a, new_v, new_p, new_a, stamp_it;
  logic [1:0] op_status;
  logic [ble_pkg::SizeW-1:0] new_size;
  logic [ble_pkg::TotalW-1:0] old_contrib, new_contrib, total_after;

  ble_store #(.ENTRIES(ENTRIES)) u_store (
    .clk(clk), .raddr(rd_addr), .rsize(rsize), .rstamp(rstamp),
    .we(mem_we), .waddr(eidx), .wsize(new_size), .wstamp(use_counter)
  );

  assign in_stall = (state != S_IDLE);
  assign eidx = idx[AW-1:0];
  assign in_range = ({{(32-ble_pkg::IdxW){1'b0}}, idx} < 32'(ENTRIES));
  assign budget_bytes = {{(ble_pkg::TotalW-ble_pkg::BudgetW-ble_pkg::GibShift){1'b0}},
                         budget_gb, {ble_pkg::GibShift{1'b0}}};
  assign over = (budget_gb != '0) && (eph_total > budget_bytes);
  assign out_free = !out_valid || !out_stall;
  assign emit = out_free && ((state == S_APPLY) || (state == S_FINISH)
                || ((state == S_EAPPLY) && held));
  assign scan_last = (scan_cnt == CW'(ENTRIES));
  assign elig = !scan_last && valid_marks[rd_addr] && !pinned_marks[rd_addr]
                && !active_marks[rd_addr];
  assign take = scan_pend && (!found || (rstamp < best_stamp));
  assign mem_we = (state == S_APPLY) && out_free && stamp_it;

  always_comb begin
    case (state)
      S_IDLE: rd_addr = entry_index[AW-1:0];
      S_APPLY: rd_addr = eidx;
      S_SCAN: rd_addr = scan_cnt[AW-1:0];
      default: rd_addr = best;
    endcase
  end

  always_comb begin
    cur_v = in_range && valid_marks[eidx];
    cur_p = in_range && pinned_marks[eidx];
    cur_a = in_range && active_marks[eidx];
    new_v = cur_v;
    new_p = cur_p;
    new_a = cur_a;
    op_status = cur_v ? ble_pkg::ST_OK : ble_pkg::ST_INVALID;
    stamp_it = 1'b0;
    if (in_range) begin
      case (op)
        ble_pkg::OP_RECORD: begin
          new_v = 1'b1;
          stamp_it = 1'b1;
          op_status = ble_pkg::ST_OK;
        end
        ble_pkg::OP_TOUCH: stamp_it = cur_v;
        ble_pkg::OP_SET_ACTIVE: begin
          new_a = 1'b1;
          stamp_it = cur_v;
        end
        ble_pkg::OP_CLR_ACTIVE: new_a = 1'b0;
        ble_pkg::OP_SET_PINNED: new_p = flag;
        ble_pkg::OP_REMOVE: begin
          new_v = 1'b0;
          new_p = 1'b0;
          new_a = 1'b0;
          op_status = ble_pkg::ST_OK;
        end
        default: ;
      endcase
    end
    new_size = (op == ble_pkg::OP_RECORD) ? size_in : rsize;
    old_contrib = (cur_v && !cur_p) ? ble_pkg::TotalW'(rsize) : '0;
    new_contrib = (new_v && !new_p) ? ble_pkg::TotalW'(new_size) : '0;
    total_after = eph_total - old_contrib + new_contrib;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      budget_gb <= ble_pkg::BudgetReset;
      valid_marks <= '0;
      pinned_marks <= '0;
      active_marks <= '0;
      use_counter <= '0;
      eph_total <= '0;
      held <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) budget_gb <= cfg_data;
      out_valid <= emit || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= ble_pkg::op_t'(operation);
            idx <= entry_index;
            flag <= flag_value;
            size_in <= entry_size;
            held <= 1'b0;
            state <= (ble_pkg::op_t'(operation) == ble_pkg::OP_ENFORCE) ? S_CHECK : S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            result_index <= idx;
            evicted <= 1'b0;
            last_result <= 1'b1;
            entry_pinned <= new_p;
            entry_active <= new_a;
            ephemeral_total <= total_after;
            status <= op_status;
            eph_total <= total_after;
            if (in_range) begin
              valid_marks[eidx] <= new_v;
              pinned_marks[eidx] <= new_p;
              active_marks[eidx] <= new_a;
            end
            if (stamp_it) use_counter <= use_counter + 1'b1;
            state <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (over) begin
            scan_cnt <= '0;
            scan_pend <= 1'b0;
            found <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          // Stamp data is registered, so it belongs to the address of the previous scan step.
          if (take) begin
            found <= 1'b1;
            best <= AW'(scan_cnt - 1'b1);
            best_stamp <= rstamp;
          end
          scan_pend <= elig;
          if (scan_last) begin
            state <= (found || take) ? S_EREAD : S_FINISH;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_EREAD: state <= S_EAPPLY;
        S_EAPPLY: begin
          // The previous eviction is sent only once another one is certain.
          if (out_free) begin
            if (held) begin
              result_index <= ble_pkg::IdxW'(held_idx);
              evicted <= 1'b1;
              last_result <= 1'b0;
              entry_pinned <= 1'b0;
              entry_active <= 1'b0;
              ephemeral_total <= eph_total;
              status <= ble_pkg::ST_OK;
            end
            held <= 1'b1;
            held_idx <= best;
            eph_total <= eph_total - ble_pkg::TotalW'(rsize);
            valid_marks[best] <= 1'b0;
            pinned_marks[best] <= 1'b0;
            active_marks[best] <= 1'b0;
            state <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            result_index <= held ? ble_pkg::IdxW'(held_idx) : '0;
            evicted <= held;
            last_result <= 1'b1;
            entry_pinned <= 1'b0;
            entry_active <= 1'b0;
            ephemeral_total <= eph_total;
            status <= over ? ble_pkg::ST_OVER : ble_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && !in_stall |=> in_stall)
    else $error("sequencer did not leave idle on an accepted beat");
  assert property (@(posedge clk) disable iff (rst)
      out_valid && out_stall |=> out_valid && $stable(result_index) && $stable(ephemeral_total))
    else $error("stalled result beat was dropped or changed");
  assert property (@(posedge clk) disable iff (rst) out_valid && !evicted |-> last_result)
    else $error("non-eviction result beat is not the last one");
  assert property (@(posedge clk) disable iff (rst)
      (state == S_SCAN) |-> (scan_cnt <= CW'(ENTRIES)))
    else $error("scan counter ran past the table");
endmodule

// ----- src/ble_store.sv -----
// Size and stamp memories of the eviction table, one read port each with
// registered data and one shared write port. Depends on ble_pkg.
module ble_store #(
  parameter int unsigned ENTRIES = ble_pkg::EntriesDefault,
  localparam int unsigned AW = $clog2(ENTRIES)
) (
  input  logic clk,
  input  logic [AW-1:0] raddr,
  output logic [ble_pkg::SizeW-1:0] rsize,
  output logic [ble_pkg::StampW-1:0] rstamp,
  input  logic we,
  input  logic [AW-1:0] waddr,
  input  logic [ble_pkg::SizeW-1:0] wsize,
  input  logic [ble_pkg::StampW-1:0] wstamp
);
  logic [ble_pkg::SizeW-1:0] size_mem [ENTRIES];
  logic [ble_pkg::StampW-1:0] stamp_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      size_mem[waddr] <= wsize;
      stamp_mem[waddr] <= wstamp;
    end
    rsize <= size_mem[raddr];
    rstamp <= stamp_mem[raddr];
  end
endmodule
